// File: design/sws_pkg.sv
// Shared types, codes and defaults for the stop-and-wait sender.
`default_nettype none

package sws_pkg;

   // Field widths of the request and response payloads.
   localparam int OPCODE_BITS   = 2;
   localparam int ACK_BITS      = 16;
   localparam int SEQ_OUT_BITS  = 16;
   localparam int TIME_OUT_BITS = 16;
   localparam int CFG_BITS      = 16;

   // Configuration port geometry.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Parameter defaults.
   localparam int SEQ_BITS_DEFAULT  = 16;
   localparam int TIME_BITS_DEFAULT = 16;

   // Register reset values, in milliseconds.
   localparam logic [CFG_BITS-1:0] INIT_RTT_RESET = 16'd500;
   localparam logic [CFG_BITS-1:0] INIT_DEV_RESET = 16'd50;
   localparam logic [CFG_BITS-1:0] MAX_RTO_RESET  = 16'd5000;

   // Request opcodes.
   localparam logic [OPCODE_BITS-1:0] OP_SEND = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_TICK = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_ACK  = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_NONE = 2'd3;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_INIT_RTT = 2'd0;
   localparam logic [1:0] REG_INIT_DEV = 2'd1;
   localparam logic [1:0] REG_MAX_RTO  = 2'd2;

endpackage

`default_nettype wire

// File: design/sws_if.sv
// Request and response channel interfaces of the stop-and-wait sender.
`default_nettype none

interface sws_req_if import sws_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [ACK_BITS-1:0]    ack_seq;

   modport source (output valid, output opcode, output ack_seq, input ready);
   modport sink   (input valid, input opcode, input ack_seq, output ready);
endinterface

interface sws_rsp_if import sws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     transmit;
   logic                     is_retransmit;
   logic [SEQ_OUT_BITS-1:0]  seq_out;
   logic                     packet_done;
   logic                     rejected;
   logic [TIME_OUT_BITS-1:0] rtt_ms;
   logic [TIME_OUT_BITS-1:0] timeout_ms;
   logic                     busy_res;

   modport source (
      output valid, output transmit, output is_retransmit, output seq_out,
      output packet_done, output rejected, output rtt_ms, output timeout_ms,
      output busy_res, input ready
   );
   modport sink (
      input valid, input transmit, input is_retransmit, input seq_out,
      input packet_done, input rejected, input rtt_ms, input timeout_ms,
      input busy_res, output ready
   );
endinterface

`default_nettype wire

// File: design/stop_and_wait_sender_adaptive_rto.sv
// Top level of the stop-and-wait ARQ sender with adaptive retransmit timeout.
//
// This block is the control half of a stop-and-wait sender. Each request is
// one event (send a new packet, a one millisecond tick, or an acknowledgement)
// and produces exactly one response that says whether to transmit, whether it
// is a retransmission, whether the outstanding packet completed, whether the
// request was rejected, and the current sequence number, smoothed RTT,
// timeout and busy status. The block accepts one request every clock cycle:
// a request is captured in an input register, evaluated against the protocol
// state in one pass of shift-and-add logic, and its response is held in an
// output register, so a request passes through both registers before its
// response is offered, and the throughput is one request per cycle as long
// as the response side keeps taking responses.
// When the response register is full and not taken, the input register holds
// its request and ready drops only then. The RTT estimator uses the classic
// integer smoothed-RTT and mean-deviation form, and samples from
// retransmitted packets are not used. Configuration registers sit at byte
// addresses 0 (initial RTT), 4
// (initial deviation) and 8 (timeout cap); writing either initial value
// reloads the RTT, deviation and timeout at once. Registers should only be
// written while no response is pending.
`default_nettype none

module stop_and_wait_sender_adaptive_rto
   import sws_pkg::*;
#(
   parameter int SEQ_BITS  = SEQ_BITS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   sws_req_if.sink                  req_chan,
   sws_rsp_if.source                rsp_chan,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire  [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // Saturation works on a word wide enough for rtt + 4*dev at any time width
   // and for a full register value.
   localparam int SATW = ((TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS) + 4;
   localparam logic [SATW-1:0]      TIME_MAX_W = (SATW'(1) << TIME_BITS) - SATW'(1);
   localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [SATW-1:0] v);
      return (v > TIME_MAX_W) ? TIME_MAX : v[TIME_BITS-1:0];
   endfunction

   function automatic logic [SATW-1:0] widen_cfg(input logic [CFG_BITS-1:0] v);
      logic [SATW+CFG_BITS-1:0] w;
      w = {{SATW{1'b0}}, v};
      return w[SATW-1:0];
   endfunction

   // Timeout from an rtt and a deviation: rtt + 4*dev, saturated.
   function automatic logic [TIME_BITS-1:0] rto_of(input logic [TIME_BITS-1:0] rtt,
                                                  input logic [TIME_BITS-1:0] dev);
      logic [SATW-1:0] sum;
      sum = SATW'(rtt) + (SATW'(dev) << 2);
      return sat_time(sum);
   endfunction

   localparam logic [TIME_BITS-1:0] RTT_RESET = sat_time(widen_cfg(INIT_RTT_RESET));
   localparam logic [TIME_BITS-1:0] DEV_RESET = sat_time(widen_cfg(INIT_DEV_RESET));

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CFG_BITS-1:0] init_rtt_ff, init_rtt_in;
   logic [CFG_BITS-1:0] init_dev_ff, init_dev_in;
   logic [CFG_BITS-1:0] max_rto_ff,  max_rto_in;
   logic                csr_write;
   logic                reload;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      init_rtt_in = init_rtt_ff;
      init_dev_in = init_dev_ff;
      max_rto_in  = max_rto_ff;
      reload      = 1'b0;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_INIT_RTT: begin
               init_rtt_in = csr_pwdata[CFG_BITS-1:0];
               reload      = 1'b1;
            end
            REG_INIT_DEV: begin
               init_dev_in = csr_pwdata[CFG_BITS-1:0];
               reload      = 1'b1;
            end
            REG_MAX_RTO: begin
               max_rto_in = csr_pwdata[CFG_BITS-1:0];
            end
            default: begin
               // Addresses past the register list are ignored.
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INIT_RTT: csr_prdata = CSR_DATA_BITS'(init_rtt_ff);
         REG_INIT_DEV: csr_prdata = CSR_DATA_BITS'(init_dev_ff);
         REG_MAX_RTO:  csr_prdata = CSR_DATA_BITS'(max_rto_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_rtt_ff <= INIT_RTT_RESET;
         init_dev_ff <= INIT_DEV_RESET;
         max_rto_ff  <= MAX_RTO_RESET;
      end else begin
         init_rtt_ff <= init_rtt_in;
         init_dev_ff <= init_dev_in;
         max_rto_ff  <= max_rto_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register and pipeline flow control
   // ------------------------------------------------------------------
   logic                   in_valid_ff, in_valid_in;
   logic [OPCODE_BITS-1:0] in_opcode_ff;
   logic [ACK_BITS-1:0]    in_ack_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   advance;
   logic                   req_take;

   // The evaluation stage moves whenever the response register is free or
   // being emptied in this cycle.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_chan.opcode;
         in_ack_ff    <= req_chan.ack_seq;
      end
   end

   // ------------------------------------------------------------------
   // Protocol state and per-request evaluation
   // ------------------------------------------------------------------
   logic [SEQ_BITS-1:0]  seq_ff,  seq_in;
   logic [TIME_BITS-1:0] rtt_ff,  rtt_in;
   logic [TIME_BITS-1:0] dev_ff,  dev_in;
   logic [TIME_BITS-1:0] rto_ff,  rto_in;
   logic [TIME_BITS-1:0] wait_ff, wait_in;
   logic                 busy_ff, busy_in;
   logic                 retx_ff, retx_in;

   logic                 ev_transmit, ev_retx, ev_done, ev_rej;
   logic [SEQ_BITS-1:0]  ev_seq;

   // Tick path: saturating wait count and timeout doubling up to the cap.
   logic [TIME_BITS-1:0] wait_inc;
   logic                 fire;
   logic [TIME_BITS:0]   rto_doubled;
   logic [TIME_BITS-1:0] rto_cap;
   logic [TIME_BITS-1:0] rto_backoff;

   assign wait_inc    = (wait_ff == TIME_MAX) ? wait_ff : wait_ff + TIME_BITS'(1);
   assign fire        = (wait_inc >= rto_ff);
   assign rto_doubled = {rto_ff, 1'b0};
   assign rto_cap     = sat_time(widen_cfg(max_rto_ff));
   assign rto_backoff = (rto_doubled < {1'b0, rto_cap}) ? rto_doubled[TIME_BITS-1:0] : rto_cap;

   // Ack path: the wait count is the RTT sample. The new deviation uses the
   // old smoothed RTT, and the new timeout uses both new estimates.
   logic                 ack_match;
   logic [TIME_BITS-1:0] diff;
   logic [TIME_BITS+1:0] dev_sum;
   logic [TIME_BITS+1:0] rtt_sum;
   logic [TIME_BITS-1:0] dev_est;
   logic [TIME_BITS-1:0] rtt_est;

   assign ack_match = (SEQ_BITS'(in_ack_ff) == seq_ff);
   assign diff      = (wait_ff >= rtt_ff) ? wait_ff - rtt_ff : rtt_ff - wait_ff;
   assign dev_sum   = ((TIME_BITS+2)'(dev_ff) << 1) + (TIME_BITS+2)'(dev_ff)
                      + (TIME_BITS+2)'(diff);
   assign rtt_sum   = ((TIME_BITS+2)'(rtt_ff) << 1) + (TIME_BITS+2)'(rtt_ff)
                      + (TIME_BITS+2)'(wait_ff);
   assign dev_est   = dev_sum[TIME_BITS+1:2];
   assign rtt_est   = rtt_sum[TIME_BITS+1:2];

   // Estimates reloaded from the configuration registers.
   logic [TIME_BITS-1:0] rtt_load;
   logic [TIME_BITS-1:0] dev_load;

   assign rtt_load = sat_time(widen_cfg(init_rtt_in));
   assign dev_load = sat_time(widen_cfg(init_dev_in));

   always_comb begin
      seq_in      = seq_ff;
      rtt_in      = rtt_ff;
      dev_in      = dev_ff;
      rto_in      = rto_ff;
      wait_in     = wait_ff;
      busy_in     = busy_ff;
      retx_in     = retx_ff;
      ev_transmit = 1'b0;
      ev_retx     = 1'b0;
      ev_done     = 1'b0;
      ev_rej      = 1'b0;
      ev_seq      = seq_ff;

      if (advance) begin
         unique case (in_opcode_ff)
            OP_SEND: begin
               if (busy_ff) begin
                  ev_rej = 1'b1;
               end else begin
                  busy_in     = 1'b1;
                  retx_in     = 1'b0;
                  wait_in     = '0;
                  ev_transmit = 1'b1;
               end
            end
            OP_TICK: begin
               if (busy_ff) begin
                  if (fire) begin
                     rto_in      = rto_backoff;
                     retx_in     = 1'b1;
                     wait_in     = '0;
                     ev_transmit = 1'b1;
                     ev_retx     = 1'b1;
                  end else begin
                     wait_in = wait_inc;
                  end
               end
            end
            OP_ACK: begin
               if (!busy_ff) begin
                  ev_rej = 1'b1;
               end else if (ack_match) begin
                  // Only a packet sent once gives a usable sample.
                  if (!retx_ff) begin
                     dev_in = dev_est;
                     rtt_in = rtt_est;
                     rto_in = rto_of(rtt_est, dev_est);
                  end
                  seq_in  = seq_ff + SEQ_BITS'(1);
                  busy_in = 1'b0;
                  retx_in = 1'b0;
                  wait_in = '0;
                  ev_done = 1'b1;
               end else begin
                  // A stale or foreign ack restarts the wait.
                  wait_in = '0;
               end
            end
            OP_NONE: begin
               // Reports status only.
            end
            default: begin
            end
         endcase
      end

      // Only completed packets report the number they completed.
      if (!ev_done) begin
         ev_seq = seq_in;
      end

      if (reload) begin
         rtt_in = rtt_load;
         dev_in = dev_load;
         rto_in = rto_of(rtt_load, dev_load);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         rtt_ff  <= RTT_RESET;
         dev_ff  <= DEV_RESET;
         rto_ff  <= rto_of(RTT_RESET, DEV_RESET);
         wait_ff <= '0;
         busy_ff <= 1'b0;
         retx_ff <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         rtt_ff  <= rtt_in;
         dev_ff  <= dev_in;
         rto_ff  <= rto_in;
         wait_ff <= wait_in;
         busy_ff <= busy_in;
         retx_ff <= retx_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic                     rsp_transmit_ff;
   logic                     rsp_retx_ff;
   logic [SEQ_OUT_BITS-1:0]  rsp_seq_ff;
   logic                     rsp_done_ff;
   logic                     rsp_rej_ff;
   logic [TIME_OUT_BITS-1:0] rsp_rtt_ff;
   logic [TIME_OUT_BITS-1:0] rsp_rto_ff;
   logic                     rsp_busy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_transmit_ff <= ev_transmit;
         rsp_retx_ff     <= ev_retx;
         rsp_seq_ff      <= SEQ_OUT_BITS'(ev_seq);
         rsp_done_ff     <= ev_done;
         rsp_rej_ff      <= ev_rej;
         rsp_rtt_ff      <= TIME_OUT_BITS'(rtt_in);
         rsp_rto_ff      <= TIME_OUT_BITS'(rto_in);
         rsp_busy_ff     <= busy_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.transmit      = rsp_transmit_ff;
   assign rsp_chan.is_retransmit = rsp_retx_ff;
   assign rsp_chan.seq_out       = rsp_seq_ff;
   assign rsp_chan.packet_done   = rsp_done_ff;
   assign rsp_chan.rejected      = rsp_rej_ff;
   assign rsp_chan.rtt_ms        = rsp_rtt_ff;
   assign rsp_chan.timeout_ms    = rsp_rto_ff;
   assign rsp_chan.busy_res      = rsp_busy_ff;

endmodule

`default_nettype wire

// File: design/sws_checker.sv
// Port-level assertions for the stop-and-wait sender, bound to the top level.
`default_nettype none

module sws_checker
   import sws_pkg::*;
(
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire                     transmit,
   input wire                     is_retransmit,
   input wire [SEQ_OUT_BITS-1:0]  seq_out,
   input wire                     packet_done,
   input wire                     rejected,
   input wire [TIME_OUT_BITS-1:0] timeout_ms,
   input wire                     busy_res
);

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending right after reset");

   // A stalled response keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(seq_out)
         && $stable(timeout_ms) && $stable(transmit) && $stable(packet_done))
      else $error("stalled response changed");

   // A retransmission only happens for a packet still waiting for its ack.
   a_retx_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_retransmit |-> transmit && busy_res && !rejected)
      else $error("retransmit without an outstanding packet");

   // A completed packet leaves the sender idle and sends nothing.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && packet_done |-> !busy_res && !transmit && !rejected)
      else $error("completed packet left sender busy");

endmodule

bind stop_and_wait_sender_adaptive_rto sws_checker u_sws_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .transmit      (rsp_chan.transmit),
   .is_retransmit (rsp_chan.is_retransmit),
   .seq_out       (rsp_chan.seq_out),
   .packet_done   (rsp_chan.packet_done),
   .rejected      (rsp_chan.rejected),
   .timeout_ms    (rsp_chan.timeout_ms),
   .busy_res      (rsp_chan.busy_res)
);

`default_nettype wire
